FILE: hdl/rddm_pkg.sv
// ----------------------------------------------------------------------------
// rddm_pkg: shared types and constants
// Command codes, register indexes, queue job word and mixer state encoding
// for the ramped differential drive mixer.
// ----------------------------------------------------------------------------
package rddm_pkg;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    // command word mode codes
    localparam logic [1:0] MODE_TICK   = 2'd0;
    localparam logic [1:0] MODE_STOP   = 2'd1;
    localparam logic [1:0] MODE_DIRECT = 2'd2;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_ACCEL_STEP    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_DECEL_STEP    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_REVERSE_STEP  = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_UPDATE_PERIOD = 2'd3;

    localparam logic signed [7:0] SPEED_LIMIT  = 8'sd100;
    localparam logic [7:0]        DEADBAND     = 8'd5;
    localparam logic [7:0]        SPOT_LIMIT   = 8'd10;
    localparam logic [7:0]        SPOT_FLOOR   = 8'd25;
    localparam logic [15:0]       MIN_INTERVAL = 16'd10;

    // one mix job: speeds to mix and ramped speeds to report
    typedef struct packed {
        logic signed [7:0] mix_straight;
        logic signed [7:0] mix_turn;
        logic signed [7:0] ramped_straight;
        logic signed [7:0] ramped_turn;
    } job_t;

    typedef enum logic [2:0] {
        MIX_IDLE,
        MIX_DEADBAND,
        MIX_SUM,
        MIX_NORM,
        MIX_DIV,
        MIX_DONE
    } mix_state_t;

endpackage

FILE: hdl/rddm_if.sv
// ----------------------------------------------------------------------------
// rddm_if: command and drive channels
// Valid/ready channels carrying the command word and the drive word.
// ----------------------------------------------------------------------------
interface rddm_cmd_if;
    logic              valid;
    logic              ready;
    logic [1:0]        mode;
    logic signed [7:0] cmd_straight;
    logic signed [7:0] cmd_turn;

    modport source (output valid, output mode, output cmd_straight, output cmd_turn,
                    input ready);
    modport sink   (input valid, input mode, input cmd_straight, input cmd_turn,
                    output ready);
endinterface

interface rddm_drive_if;
    logic              valid;
    logic              ready;
    logic signed [7:0] left_drive;
    logic signed [7:0] right_drive;
    logic signed [7:0] ramped_straight;
    logic signed [7:0] ramped_turn;

    modport source (output valid, output left_drive, output right_drive,
                    output ramped_straight, output ramped_turn, input ready);
    modport sink   (input valid, input left_drive, input right_drive,
                    input ramped_straight, input ramped_turn, output ready);
endinterface

FILE: hdl/ramped_differential_drive_mixer.sv
// ----------------------------------------------------------------------------
// ramped_differential_drive_mixer: arcade drive mixer with ramped speeds
//
//   port    | dir  | carries
//   --------+------+--------------------------------------------------
//   cmd     | sink | mode, cmd_straight, cmd_turn (tick / stop / direct)
//   drive   | src  | left_drive, right_drive, ramped_straight, ramped_turn
//   cfg_*   | in   | register write: index 0..3, 16-bit data
//
// The intake takes one command word per cycle while the two-entry job queue
// has room; ticks that produce no drive word never reach the queue.
// The mixer steps each drive word through deadband, sum and normalization states,
// plus a 7-step divider on overflow; that mixer sequence sets the sustained rate.
// Reset clears the ramped speeds, the tick count, the queue and the output.
// A stalled drive word holds in the output register; the next job waits in
// the mixer and further commands fill the queue before cmd.ready drops.
// ----------------------------------------------------------------------------
module ramped_differential_drive_mixer (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [rddm_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [rddm_pkg::CFG_DATA_W-1:0]  cfg_data,
    rddm_cmd_if.sink                         cmd,
    rddm_drive_if.source                     drive
);

    logic           q_push;
    logic           q_full;
    logic           q_pop;
    logic           q_empty;
    rddm_pkg::job_t q_push_job;
    rddm_pkg::job_t q_pop_job;

    rddm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_job     (q_push_job)
    );

    rddm_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (q_push_job),
        .full     (q_full),
        .pop      (q_pop),
        .pop_job  (q_pop_job),
        .empty    (q_empty)
    );

    rddm_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_job   (q_pop_job),
        .q_pop   (q_pop),
        .drive   (drive)
    );

endmodule

FILE: hdl/rddm_front.sv
// ----------------------------------------------------------------------------
// rddm_front: command intake and speed ramp
// Holds the configuration registers, counts ticks, steps the ramped speeds
// and pushes one mix job for each command word that yields a drive word.
// ----------------------------------------------------------------------------
module rddm_front (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [rddm_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [rddm_pkg::CFG_DATA_W-1:0]    cfg_data,
    rddm_cmd_if.sink                           cmd,
    input  logic                               q_full,
    output logic                               q_push,
    output rddm_pkg::job_t                     q_job
);

    logic [7:0]        accel_reg;
    logic [7:0]        decel_reg;
    logic [7:0]        reverse_reg;
    logic [15:0]       interval_reg;
    logic signed [7:0] cur_straight_reg, cur_straight_next;
    logic signed [7:0] cur_turn_reg, cur_turn_next;
    logic [15:0]       elapsed_reg, elapsed_next;

    logic              accept;
    logic [15:0]       interval_eff;
    logic [15:0]       elapsed_inc;
    logic signed [7:0] tgt_straight;
    logic signed [7:0] tgt_turn;
    logic signed [7:0] ramp_straight;
    logic signed [7:0] ramp_turn;

    function automatic logic signed [7:0] clamp_cmd(input logic signed [7:0] v);
        if (v > rddm_pkg::SPEED_LIMIT)
            return rddm_pkg::SPEED_LIMIT;
        else if (v < -rddm_pkg::SPEED_LIMIT)
            return -rddm_pkg::SPEED_LIMIT;
        else
            return v;
    endfunction

    function automatic logic signed [10:0] step_of(input logic [7:0] s);
        return (s == 8'd0) ? 11'sd1 : signed'({3'b000, s});
    endfunction

    // one ramp step of cur toward tgt; both stay within +-100
    function automatic logic signed [7:0] ramp(
        input logic signed [7:0] cur,
        input logic signed [7:0] tgt,
        input logic [7:0]        acc,
        input logic [7:0]        dec,
        input logic [7:0]        rev
    );
        logic signed [10:0] c;
        logic signed [10:0] t;
        logic signed [10:0] s;
        logic signed [10:0] sum;
        logic signed [10:0] res;
        logic signed [10:0] cm;
        logic signed [10:0] tm;
        c   = {{3{cur[7]}}, cur};
        t   = {{3{tgt[7]}}, tgt};
        cm  = (c < 0) ? -c : c;
        tm  = (t < 0) ? -t : t;
        res = c;
        sum = c;
        s   = step_of(acc);
        if (c == t)
        begin
            res = c;
        end
        else if ((c > 0 && t < 0) || (c < 0 && t > 0))
        begin
            // reversal: brake toward zero only
            s = step_of(rev);
            if (c > 0)
            begin
                sum = c - s;
                res = (sum < 0) ? 11'sd0 : sum;
            end
            else
            begin
                sum = c + s;
                res = (sum > 0) ? 11'sd0 : sum;
            end
        end
        else
        begin
            s = (cm < tm) ? step_of(acc) : step_of(dec);
            if (t > c)
            begin
                sum = c + s;
                res = (sum > t) ? t : sum;
            end
            else
            begin
                sum = c - s;
                res = (sum < t) ? t : sum;
            end
        end
        return res[7:0];
    endfunction

    assign cmd.ready = !q_full;
    assign accept    = cmd.valid && !q_full;

    assign interval_eff  = (interval_reg < rddm_pkg::MIN_INTERVAL) ?
                           rddm_pkg::MIN_INTERVAL : interval_reg;
    assign elapsed_inc   = (elapsed_reg == 16'hFFFF) ? elapsed_reg : elapsed_reg + 16'd1;
    assign tgt_straight  = clamp_cmd(cmd.cmd_straight);
    assign tgt_turn      = clamp_cmd(cmd.cmd_turn);
    assign ramp_straight = ramp(cur_straight_reg, tgt_straight, accel_reg, decel_reg,
                                reverse_reg);
    assign ramp_turn     = ramp(cur_turn_reg, tgt_turn, accel_reg, decel_reg, reverse_reg);

    always_comb
    begin
        cur_straight_next = cur_straight_reg;
        cur_turn_next     = cur_turn_reg;
        elapsed_next      = elapsed_reg;
        q_push            = 1'b0;
        q_job             = '{mix_straight: cur_straight_reg, mix_turn: cur_turn_reg,
                              ramped_straight: cur_straight_reg,
                              ramped_turn: cur_turn_reg};
        if (accept)
        begin
            case (cmd.mode)
                rddm_pkg::MODE_TICK:
                begin
                    if (elapsed_inc >= interval_eff)
                    begin
                        elapsed_next      = 16'd0;
                        cur_straight_next = ramp_straight;
                        cur_turn_next     = ramp_turn;
                        q_push            = 1'b1;
                        q_job             = '{mix_straight: ramp_straight,
                                              mix_turn: ramp_turn,
                                              ramped_straight: ramp_straight,
                                              ramped_turn: ramp_turn};
                    end
                    else
                    begin
                        elapsed_next = elapsed_inc;
                    end
                end
                rddm_pkg::MODE_STOP:
                begin
                    // mixing zeros gives zero drive
                    cur_straight_next = 8'sd0;
                    cur_turn_next     = 8'sd0;
                    q_push            = 1'b1;
                    q_job             = '{default: 8'sd0};
                end
                rddm_pkg::MODE_DIRECT:
                begin
                    q_push = 1'b1;
                    q_job  = '{mix_straight: cmd.cmd_straight, mix_turn: cmd.cmd_turn,
                               ramped_straight: cur_straight_reg,
                               ramped_turn: cur_turn_reg};
                end
                default:
                begin
                    q_push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_straight_reg <= 8'sd0;
            cur_turn_reg     <= 8'sd0;
            elapsed_reg      <= 16'd0;
        end
        else
        begin
            cur_straight_reg <= cur_straight_next;
            cur_turn_reg     <= cur_turn_next;
            elapsed_reg      <= elapsed_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accel_reg    <= 8'd5;
            decel_reg    <= 8'd5;
            reverse_reg  <= 8'd10;
            interval_reg <= 16'd20;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                rddm_pkg::REG_ACCEL_STEP:    accel_reg    <= cfg_data[7:0];
                rddm_pkg::REG_DECEL_STEP:    decel_reg    <= cfg_data[7:0];
                rddm_pkg::REG_REVERSE_STEP:  reverse_reg  <= cfg_data[7:0];
                rddm_pkg::REG_UPDATE_PERIOD: interval_reg <= cfg_data[15:0];
                default:                     interval_reg <= interval_reg;
            endcase
        end
    end

endmodule

FILE: hdl/rddm_queue.sv
// ----------------------------------------------------------------------------
// rddm_queue: two-entry job queue
// Decouples command intake from the mixer.
// ----------------------------------------------------------------------------
module rddm_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  rddm_pkg::job_t push_job,
    output logic           full,
    input  logic           pop,
    output rddm_pkg::job_t pop_job,
    output logic           empty
);

    rddm_pkg::job_t entry_reg [2];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     count_reg, count_next;
    logic           do_push;
    logic           do_pop;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign pop_job = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_job;
    end

endmodule

FILE: hdl/rddm_back.sv
// ----------------------------------------------------------------------------
// rddm_back: drive mixer
// Deadband, turn scaling, spot turn, overflow normalization by a shared
// bit-serial divider lane pair, and the output register.
// ----------------------------------------------------------------------------
module rddm_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_empty,
    input  rddm_pkg::job_t q_job,
    output logic           q_pop,
    rddm_drive_if.source   drive
);

    rddm_pkg::mix_state_t state_reg, state_next;

    logic signed [7:0] st_reg, st_next;
    logic signed [7:0] tu_reg, tu_next;
    logic signed [7:0] rs_reg, rs_next;
    logic signed [7:0] rt_reg, rt_next;
    logic signed [7:0] fs_reg, fs_next;
    logic signed [7:0] a_reg, a_next;
    logic signed [8:0] l_reg, l_next;
    logic signed [8:0] r_reg, r_next;
    logic [7:0]        m_reg, m_next;
    logic [14:0]       num_l_reg, num_l_next;
    logic [14:0]       num_r_reg, num_r_next;
    logic [6:0]        quot_l_reg, quot_l_next;
    logic [6:0]        quot_r_reg, quot_r_next;
    logic [2:0]        cnt_reg, cnt_next;

    logic              out_valid_reg, out_valid_next;
    logic signed [7:0] left_reg, left_next;
    logic signed [7:0] right_reg, right_next;
    logic signed [7:0] ors_reg, ors_next;
    logic signed [7:0] ort_reg, ort_next;

    logic [7:0]        st_mag, ft_mag, fs_mag, a_mag;
    logic [7:0]        lm, rm, lsp, rsp;
    logic signed [7:0] ft;
    logic signed [8:0] l9, r9;
    logic [14:0]       trial;
    logic              out_free;

    function automatic logic [7:0] mag8(input logic signed [7:0] v);
        return v[7] ? 8'(-v) : 8'(v);
    endfunction

    function automatic logic [7:0] mag9(input logic signed [8:0] v);
        logic [8:0] t;
        t = v[8] ? 9'(-v) : 9'(v);
        return t[7:0];
    endfunction

    // floor(x/5) for x below 1024: x*205 >> 10
    function automatic logic [7:0] div5(input logic [9:0] x);
        logic [17:0] p;
        p = 18'(x) * 18'd205;
        return p[17:10];
    endfunction

    function automatic logic signed [8:0] apply_sign(input logic neg, input logic [7:0] m);
        return neg ? -signed'({1'b0, m}) : signed'({1'b0, m});
    endfunction

    function automatic logic [7:0] spot_floor(input logic [7:0] m);
        return (m != 8'd0 && m < rddm_pkg::SPOT_FLOOR) ? rddm_pkg::SPOT_FLOOR : m;
    endfunction

    assign out_free = !out_valid_reg || drive.ready;

    always_comb
    begin
        state_next     = state_reg;
        st_next        = st_reg;
        tu_next        = tu_reg;
        rs_next        = rs_reg;
        rt_next        = rt_reg;
        fs_next        = fs_reg;
        a_next         = a_reg;
        l_next         = l_reg;
        r_next         = r_reg;
        m_next         = m_reg;
        num_l_next     = num_l_reg;
        num_r_next     = num_r_reg;
        quot_l_next    = quot_l_reg;
        quot_r_next    = quot_r_reg;
        cnt_next       = cnt_reg;
        out_valid_next = (out_valid_reg && !drive.ready);
        left_next      = left_reg;
        right_next     = right_reg;
        ors_next       = ors_reg;
        ort_next       = ort_reg;
        q_pop          = 1'b0;

        st_mag = mag8(st_reg);
        ft_mag = mag8(tu_reg);
        ft     = (ft_mag < rddm_pkg::DEADBAND) ? 8'sd0 : tu_reg;
        a_mag  = div5({mag8(ft), 2'b00});
        fs_mag = mag8(fs_reg);
        l9     = {fs_reg[7], fs_reg} + {a_reg[7], a_reg};
        r9     = {fs_reg[7], fs_reg} - {a_reg[7], a_reg};
        lsp    = spot_floor(div5({mag9(l9), 2'b00}));
        rsp    = spot_floor(div5({mag9(r9), 2'b00}));
        lm     = mag9(l_reg);
        rm     = mag9(r_reg);
        trial  = 15'(m_reg) << cnt_reg;

        case (state_reg)
            rddm_pkg::MIX_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    st_next    = q_job.mix_straight;
                    tu_next    = q_job.mix_turn;
                    rs_next    = q_job.ramped_straight;
                    rt_next    = q_job.ramped_turn;
                    state_next = rddm_pkg::MIX_DEADBAND;
                end
            end
            rddm_pkg::MIX_DEADBAND:
            begin
                fs_next    = (st_mag < rddm_pkg::DEADBAND) ? 8'sd0 : st_reg;
                a_next     = 8'(apply_sign(ft[7], a_mag));
                state_next = rddm_pkg::MIX_SUM;
            end
            rddm_pkg::MIX_SUM:
            begin
                // spot turn: scale both sides by 4/5 with a floor
                if (fs_mag < rddm_pkg::SPOT_LIMIT && a_reg != 8'sd0)
                begin
                    l_next = apply_sign(l9[8], lsp);
                    r_next = apply_sign(r9[8], rsp);
                end
                else
                begin
                    l_next = l9;
                    r_next = r9;
                end
                state_next = rddm_pkg::MIX_NORM;
            end
            rddm_pkg::MIX_NORM:
            begin
                m_next = (lm > rm) ? lm : rm;
                if (m_next > 8'd100)
                begin
                    num_l_next  = 15'(lm) * 15'd100;
                    num_r_next  = 15'(rm) * 15'd100;
                    quot_l_next = 7'd0;
                    quot_r_next = 7'd0;
                    cnt_next    = 3'd6;
                    state_next  = rddm_pkg::MIX_DIV;
                end
                else
                begin
                    state_next = rddm_pkg::MIX_DONE;
                end
            end
            rddm_pkg::MIX_DIV:
            begin
                // one quotient bit per cycle on both lanes; quotient fits 7 bits
                if (num_l_reg >= trial)
                begin
                    num_l_next           = num_l_reg - trial;
                    quot_l_next[cnt_reg] = 1'b1;
                end
                if (num_r_reg >= trial)
                begin
                    num_r_next           = num_r_reg - trial;
                    quot_r_next[cnt_reg] = 1'b1;
                end
                if (cnt_reg == 3'd0)
                begin
                    l_next     = apply_sign(l_reg[8], {1'b0, quot_l_next});
                    r_next     = apply_sign(r_reg[8], {1'b0, quot_r_next});
                    state_next = rddm_pkg::MIX_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg - 3'd1;
                end
            end
            rddm_pkg::MIX_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    left_next      = 8'(-l_reg);
                    right_next     = r_reg[7:0];
                    ors_next       = rs_reg;
                    ort_next       = rt_reg;
                    state_next     = rddm_pkg::MIX_IDLE;
                end
            end
            default:
            begin
                state_next = rddm_pkg::MIX_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rddm_pkg::MIX_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        st_reg     <= st_next;
        tu_reg     <= tu_next;
        rs_reg     <= rs_next;
        rt_reg     <= rt_next;
        fs_reg     <= fs_next;
        a_reg      <= a_next;
        l_reg      <= l_next;
        r_reg      <= r_next;
        m_reg      <= m_next;
        num_l_reg  <= num_l_next;
        num_r_reg  <= num_r_next;
        quot_l_reg <= quot_l_next;
        quot_r_reg <= quot_r_next;
        cnt_reg    <= cnt_next;
        left_reg   <= left_next;
        right_reg  <= right_next;
        ors_reg    <= ors_next;
        ort_reg    <= ort_next;
    end

    assign drive.valid           = out_valid_reg;
    assign drive.left_drive      = left_reg;
    assign drive.right_drive     = right_reg;
    assign drive.ramped_straight = ors_reg;
    assign drive.ramped_turn     = ort_reg;

    a_drive_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (left_reg >= -8'sd100 && left_reg <= 8'sd100 &&
                           right_reg >= -8'sd100 && right_reg <= 8'sd100))
        else $error("drive word out of range");

    a_div_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rddm_pkg::MIX_DIV) |=>
            (state_reg == rddm_pkg::MIX_DIV || state_reg == rddm_pkg::MIX_DONE))
        else $error("divider left to a wrong state");

    a_div_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rddm_pkg::MIX_DIV && cnt_reg == 3'd0) |=>
            (l_reg >= -9'sd100 && l_reg <= 9'sd100 &&
             r_reg >= -9'sd100 && r_reg <= 9'sd100))
        else $error("normalized value above limit");

    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (state_reg == rddm_pkg::MIX_IDLE && !q_empty))
        else $error("job taken while mixer busy");

endmodule

FILE: test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for ramped_differential_drive_mixer
// Drives tick, stop, direct and unused command words through the cmd channel under
// random gaps and stalls. A behavioral ramp and mix predictor queues each
// expected drive word, and every word taken from the drive channel is
// checked field by field. Register settings change between phases while
// the block is idle.
// ----------------------------------------------------------------------------
module tb;

    // mode three carries no command and is dropped by the block
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    localparam int SPD_CAP     = 100;
    localparam int DEAD_ZONE   = 5;
    localparam int PIVOT_BELOW = 10;
    localparam int PIVOT_FLOOR = 25;
    localparam int MAX_GAP     = 13;
    localparam int SETTLE_CYC  = 30;
    localparam int HOLD_CYC    = 300;
    localparam int LONG_TICKS  = 60;

    typedef struct packed {
        logic signed [7:0] left;
        logic signed [7:0] right;
        logic signed [7:0] straight;
        logic signed [7:0] turn;
    } drive_word_t;

    typedef struct {
        logic [1:0]        op;
        logic signed [7:0] st;
        logic signed [7:0] tn;
        int                reps;
        bit                pinned;
        drive_word_t       want;
    } step_row_t;

    logic                             clk = 1'b0;
    logic                             rst_n;
    logic                             cfg_we;
    logic [rddm_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [rddm_pkg::CFG_DATA_W-1:0]  cfg_data;

    rddm_cmd_if   cmd ();
    rddm_drive_if drive ();

    ramped_differential_drive_mixer u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .drive     (drive)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // predictor state and register copies
    int                accel_s;
    int                decel_s;
    int                brake_s;
    int                period_ms;
    logic signed [7:0] cur_st;
    logic signed [7:0] cur_tn;
    int                ticks;

    drive_word_t pending_drive[$];
    int          predicted_words;
    int          mismatches;
    bit          calm;
    bit          burst;
    bit          hold_req;

    // directed rows: expected word typed in only where obvious
    step_row_t plan [12] = '{
        '{rddm_pkg::MODE_DIRECT,    0,    0,  1, 1'b1, '{0, 0, 0, 0}},
        '{rddm_pkg::MODE_DIRECT,    4,   -4,  1, 1'b1, '{0, 0, 0, 0}},
        '{rddm_pkg::MODE_DIRECT,    5,    0,  1, 1'b1, '{-5, 5, 0, 0}},
        '{rddm_pkg::MODE_DIRECT,  127,  127,  1, 1'b1, '{-100, 11, 0, 0}},
        '{rddm_pkg::MODE_DIRECT, -128,  127,  1, 1'b1, '{11, -100, 0, 0}},
        '{rddm_pkg::MODE_DIRECT,    0,   20,  1, 1'b1, '{-25, -25, 0, 0}},
        '{rddm_pkg::MODE_DIRECT,    9,  127,  1, 1'b0, '0},
        '{MODE_UNUSED,             -1,   -1,  1, 1'b0, '0},
        '{rddm_pkg::MODE_TICK,    127, -128, 20, 1'b0, '0},
        '{rddm_pkg::MODE_DIRECT, -128, -128,  1, 1'b0, '0},
        '{rddm_pkg::MODE_STOP,   -128,  127,  1, 1'b1, '{0, 0, 0, 0}},
        '{rddm_pkg::MODE_TICK,    -60,   60,  3, 1'b0, '0}
    };

    function automatic int iabs(input int v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic int cap_speed(input int v);
        if (v > SPD_CAP)
            return SPD_CAP;
        if (v < -SPD_CAP)
            return -SPD_CAP;
        return v;
    endfunction

    function automatic int at_least_one(input int s);
        return (s == 0) ? 1 : s;
    endfunction

    function automatic int slew(input int cur, input int tgt);
        int s;
        if (cur == tgt)
            return cur;
        // opposite sign: brake toward zero, never past it
        if ((cur > 0 && tgt < 0) || (cur < 0 && tgt > 0))
        begin
            s = at_least_one(brake_s);
            if (cur > 0)
                return (cur - s < 0) ? 0 : cur - s;
            return (cur + s > 0) ? 0 : cur + s;
        end
        s = (iabs(cur) < iabs(tgt)) ? at_least_one(accel_s) : at_least_one(decel_s);
        if (tgt > cur)
            return (cur + s > tgt) ? tgt : cur + s;
        return (cur - s < tgt) ? tgt : cur - s;
    endfunction

    function automatic int pivot_floor(input int v);
        if (v != 0 && iabs(v) < PIVOT_FLOOR)
            return (v > 0) ? PIVOT_FLOOR : -PIVOT_FLOOR;
        return v;
    endfunction

    function automatic void blend(input int st, input int tu, output int l, output int r);
        int fs;
        int ft;
        int a;
        int m;
        fs = (iabs(st) < DEAD_ZONE) ? 0 : st;
        ft = (iabs(tu) < DEAD_ZONE) ? 0 : tu;
        a  = (ft * 4) / 5;
        l  = fs + a;
        r  = fs - a;
        if (iabs(fs) < PIVOT_BELOW && a != 0)
        begin
            l = pivot_floor((l * 4) / 5);
            r = pivot_floor((r * 4) / 5);
        end
        m = (iabs(l) > iabs(r)) ? iabs(l) : iabs(r);
        if (m > SPD_CAP)
        begin
            l = (l * SPD_CAP) / m;
            r = (r * SPD_CAP) / m;
        end
        l = cap_speed(l);
        r = cap_speed(r);
    endfunction

    // advances the predictor by one command word; returns 1 if a drive word follows
    function automatic bit predict_drive(input logic [1:0] op, input logic signed [7:0] st,
                                         input logic signed [7:0] tn, output drive_word_t w);
        int l;
        int r;
        int iv;
        w = '0;
        case (op)
            rddm_pkg::MODE_TICK:
            begin
                iv = (period_ms < int'(rddm_pkg::MIN_INTERVAL)) ?
                     int'(rddm_pkg::MIN_INTERVAL) : period_ms;
                if (ticks < 65535)
                    ticks++;
                if (ticks < iv)
                    return 1'b0;
                ticks  = 0;
                cur_st = 8'(slew(cur_st, cap_speed(st)));
                cur_tn = 8'(slew(cur_tn, cap_speed(tn)));
                blend(cur_st, cur_tn, l, r);
            end
            rddm_pkg::MODE_STOP:
            begin
                cur_st = '0;
                cur_tn = '0;
                l = 0;
                r = 0;
            end
            rddm_pkg::MODE_DIRECT:
                blend(st, tn, l, r);
            default:
                return 1'b0;
        endcase
        w = '{8'(-l), 8'(r), cur_st, cur_tn};
        return 1'b1;
    endfunction

    function automatic logic signed [7:0] pick_speed();
        case ($urandom_range(0, 5))
            0:       return 8'sd127;
            1:       return -8'sd128;
            2:       return 8'sd100;
            3:       return -8'sd100;
            4:       return 8'($urandom_range(0, 30) - 15);
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic void check_field(input string tag, input logic signed [7:0] want,
                                        input logic signed [7:0] got);
        if (want !== got)
        begin
            mismatches++;
            $display("%0t ns: %s expected %0d, got %0d", $time, tag, want, got);
        end
    endfunction

    task automatic push_word(input logic [1:0] op, input logic signed [7:0] st,
                             input logic signed [7:0] tn, input bit pinned,
                             input drive_word_t pinned_word);
        int          gap;
        drive_word_t w;
        gap = (calm || burst) ? 0 : $urandom_range(0, MAX_GAP);
        if (gap != 0)
        begin
            cmd.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd.valid        <= 1'b1;
        cmd.mode         <= op;
        cmd.cmd_straight <= st;
        cmd.cmd_turn     <= tn;
        if (predict_drive(op, st, tn, w))
        begin
            pending_drive.push_back(pinned ? pinned_word : w);
            predicted_words++;
        end
        do
            @(posedge clk);
        while (!cmd.ready);
    endtask

    task automatic push_random(input logic [1:0] op);
        push_word(op, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 1'b0, '0);
    endtask

    // wait out every pending word, then a pause for a silent tick still in flight
    task automatic settle();
        cmd.valid <= 1'b0;
        while (pending_drive.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    task automatic put_reg(input logic [rddm_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [15:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            rddm_pkg::REG_ACCEL_STEP:    accel_s   = val[7:0];
            rddm_pkg::REG_DECEL_STEP:    decel_s   = val[7:0];
            rddm_pkg::REG_REVERSE_STEP:  brake_s   = val[7:0];
            rddm_pkg::REG_UPDATE_PERIOD: period_ms = val;
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic write_settings(input logic [15:0] a, input logic [15:0] d,
                                  input logic [15:0] b, input logic [15:0] iv);
        put_reg(rddm_pkg::REG_ACCEL_STEP, a);
        put_reg(rddm_pkg::REG_DECEL_STEP, d);
        put_reg(rddm_pkg::REG_REVERSE_STEP, b);
        put_reg(rddm_pkg::REG_UPDATE_PERIOD, iv);
        cfg_we <= 1'b0;
    endtask

    task automatic run_phase(input logic [15:0] a, input logic [15:0] d, input logic [15:0] b,
                             input logic [15:0] iv, input int n, input bit squeeze);
        logic signed [7:0] tgt_st;
        logic signed [7:0] tgt_tn;
        int                sel;
        write_settings(a, d, b, iv);
        tgt_st = pick_speed();
        tgt_tn = pick_speed();
        for (int i = 0; i < n; i++)
        begin
            if (i % 40 == 0)
                calm = ($urandom_range(0, 5) == 0);
            if (squeeze && i == n / 2)
            begin
                // receiver holds off; words back up and cmd.ready must drop
                hold_req = 1'b1;
                burst    = 1'b1;
                repeat (24)
                    push_word(rddm_pkg::MODE_DIRECT, pick_speed(), pick_speed(), 1'b0, '0);
                burst = 1'b0;
            end
            sel = $urandom_range(0, 99);
            if (sel < 80)
            begin
                if ($urandom_range(0, 24) == 0)
                begin
                    tgt_st = pick_speed();
                    tgt_tn = pick_speed();
                end
                if ($urandom_range(0, 9) == 0)
                    push_random(rddm_pkg::MODE_TICK);
                else
                    push_word(rddm_pkg::MODE_TICK, tgt_st, tgt_tn, 1'b0, '0);
            end
            else if (sel < 85)
                push_random(rddm_pkg::MODE_STOP);
            else if (sel < 96)
                push_word(rddm_pkg::MODE_DIRECT, pick_speed(), pick_speed(), 1'b0, '0);
            else
                push_random(MODE_UNUSED);
        end
        calm = 1'b0;
        settle();
    endtask

    // stimulus
    initial
    begin
        rst_n            <= 1'b0;
        cfg_we           <= 1'b0;
        cfg_index        <= '0;
        cfg_data         <= '0;
        cmd.valid        <= 1'b0;
        cmd.mode         <= rddm_pkg::MODE_TICK;
        cmd.cmd_straight <= '0;
        cmd.cmd_turn     <= '0;
        accel_s          = 5;
        decel_s          = 5;
        brake_s          = 10;
        period_ms        = 20;
        cur_st           = '0;
        cur_tn           = '0;
        ticks            = 0;
        predicted_words  = 0;
        mismatches       = 0;
        calm             = 1'b0;
        burst            = 1'b0;
        hold_req         = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
            repeat (plan[i].reps)
                push_word(plan[i].op, plan[i].st, plan[i].tn, plan[i].pinned, plan[i].want);
        settle();

        run_phase(16'd1, 16'd1, 16'd1, 16'd10, 200, 1'b0);
        run_phase(16'd200, 16'd200, 16'd200, 16'd10, 150, 1'b1);
        // zero steps act as one, short period acts as ten
        run_phase(16'd0, 16'd0, 16'd0, 16'd3, 200, 1'b0);
        run_phase(16'($urandom_range(1, 200)), 16'($urandom_range(1, 200)),
                  16'($urandom_range(1, 200)), 16'($urandom_range(10, 40)), 200, 1'b0);
        // junk in the upper byte of the step registers
        run_phase(16'hA5FF, 16'h5A25, 16'hFF37, 16'd12, 200, 1'b0);

        // longest period: back-to-back ticks pile up, then a shorter period
        // makes the very next tick fire
        write_settings(16'd3, 16'd9, 16'd2, 16'hFFFF);
        burst = 1'b1;
        repeat (LONG_TICKS)
            push_word(rddm_pkg::MODE_TICK, pick_speed(), pick_speed(), 1'b0, '0);
        burst = 1'b0;
        settle();

        run_phase(16'd5, 16'd5, 16'd10, 16'd20, 200, 1'b0);

        if (mismatches == 0 && pending_drive.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // drive word sink and checker
    initial
    begin
        int          stall;
        drive_word_t want;
        drive_word_t got;
        drive.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                drive.ready <= 1'b0;
                repeat (HOLD_CYC) @(posedge clk);
                hold_req = 1'b0;
            end
            else
            begin
                stall = calm ? 0 : $urandom_range(0, MAX_GAP);
                if (stall != 0)
                begin
                    drive.ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
            end
            drive.ready <= 1'b1;
            do
                @(posedge clk);
            while (!drive.valid);
            got = '{drive.left_drive, drive.right_drive, drive.ramped_straight,
                    drive.ramped_turn};
            if (pending_drive.size() == 0)
            begin
                mismatches++;
                $display("%0t ns: drive word expected none, got %p", $time, got);
            end
            else
            begin
                want = pending_drive.pop_front();
                check_field("left_drive", want.left, got.left);
                check_field("right_drive", want.right, got.right);
                check_field("ramped_straight", want.straight, got.straight);
                check_field("ramped_turn", want.turn, got.turn);
            end
        end
    end

    initial
    begin
        #12_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule

FILE: filelist.f
hdl/rddm_pkg.sv
hdl/rddm_if.sv
hdl/rddm_front.sv
hdl/rddm_queue.sv
hdl/rddm_back.sv
hdl/ramped_differential_drive_mixer.sv
test/tb.sv
